/* sv/assert_macros.svh */
// Assertion macros used by the top level of the distance and bearing unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PPDB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is active.
`define PPDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* sv/ppdb_pkg.sv */
// Shared constants, widths and tables of the point pair distance and bearing unit.
package ppdb_pkg;

    localparam int COORD_WIDTH         = 24;
    localparam int ANGLE_FRACTION_BITS = 16;
    localparam int CORDIC_STEPS        = 30;

    localparam int DIST_M_WIDTH  = 25;
    localparam int DIST_FT_WIDTH = 27;
    localparam int ANGLE_WIDTH   = 26;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int XY_W     = 64;
    localparam int XY_SHIFT = 60 - COORD_WIDTH;

    localparam int Z_W     = 34;
    localparam int SWEEP_W = Z_W + 1;
    localparam int ZFRAC   = 30;
    localparam int ASH     = ZFRAC - ANGLE_FRACTION_BITS;

    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
        34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
        34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
        34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
        34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
        34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
    };
    localparam logic signed [Z_W-1:0] CORDIC_PI = ATAN_TAB[0] <<< 2;

    // Degree scaling: 180 / 3.14159265 as an exact ratio.
    localparam logic [63:0] DEG_NUM = 64'd3600000000;
    localparam logic [63:0] DEG_DEN = 64'd62831853;
    localparam int MAG_W  = Z_W;
    localparam int R_W    = MAG_W + 6;
    localparam int MLO_W  = MAG_W / 2;
    localparam int MHI_W  = MAG_W - MLO_W;
    localparam int RLO_W  = R_W / 2;
    localparam int RHI_W  = R_W - RLO_W;
    localparam int PP_W   = MHI_W + RHI_W;
    localparam int DS_W   = MAG_W + R_W;
    localparam logic [R_W-1:0] DEG_RECIP =
        R_W'((128'(DEG_NUM) << MAG_W) / 128'(DEG_DEN));
    localparam int FMT_LAT = 6;

    // Feet conversion: 3 + 280839895 / 10^9.
    localparam logic [63:0] FEET_FRAC = 64'd280839895;
    localparam logic [63:0] BILLION   = 64'd1000000000;
    localparam int FN_W   = DIFF_W + 30;
    localparam int FR_W   = FN_W - 29;
    localparam int FNLO_W = FN_W / 2;
    localparam int FNHI_W = FN_W - FNLO_W;
    localparam int FP_W   = FNHI_W + FR_W;
    localparam int FS_W   = FN_W + FR_W;
    localparam logic [FR_W-1:0] FEET_RECIP = FR_W'((128'd1 << FN_W) / 128'(BILLION));

    localparam int ANG_STAGE  = CORDIC_STEPS + 2 + FMT_LAT;
    localparam int FEET_STAGE = 9 + DIFF_W;
    localparam int OUT_STAGE  = ((ANG_STAGE > FEET_STAGE) ? ANG_STAGE : FEET_STAGE) + 1;
    localparam int ANG_DLY    = OUT_STAGE - ANG_STAGE;
    localparam int DIST_DLY   = OUT_STAGE - FEET_STAGE;

endpackage

/* sv/ppdb_cordic.sv */
// Pipelined vectoring CORDIC that gives atan2(num, den) in Q30 radians.
module ppdb_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [ppdb_pkg::DIFF_W-1:0]  i_num,
    input  logic signed [ppdb_pkg::DIFF_W-1:0]  i_den,
    output logic signed [ppdb_pkg::Z_W-1:0]     o_z
);

    logic signed [ppdb_pkg::XY_W-1:0] r_x [ppdb_pkg::CORDIC_STEPS+1];
    logic signed [ppdb_pkg::XY_W-1:0] r_y [ppdb_pkg::CORDIC_STEPS+1];
    logic signed [ppdb_pkg::Z_W-1:0]  r_z [ppdb_pkg::CORDIC_STEPS+1];
    logic                             r_zero [ppdb_pkg::CORDIC_STEPS+1];
    logic signed [ppdb_pkg::XY_W-1:0] w_x0;
    logic signed [ppdb_pkg::XY_W-1:0] w_y0;

    assign w_x0 = ppdb_pkg::XY_W'(i_den) <<< ppdb_pkg::XY_SHIFT;
    assign w_y0 = ppdb_pkg::XY_W'(i_num) <<< ppdb_pkg::XY_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_num == '0) && (i_den == '0);
            if (w_x0[ppdb_pkg::XY_W-1]) begin
                r_z[0] <= w_y0[ppdb_pkg::XY_W-1] ? -ppdb_pkg::CORDIC_PI : ppdb_pkg::CORDIC_PI;
                r_x[0] <= -w_x0;
                r_y[0] <= -w_y0;
            end else begin
                r_z[0] <= '0;
                r_x[0] <= w_x0;
                r_y[0] <= w_y0;
            end
            for (int i = 0; i < ppdb_pkg::CORDIC_STEPS; i++) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][ppdb_pkg::XY_W-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ppdb_pkg::ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ppdb_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    assign o_z = r_zero[ppdb_pkg::CORDIC_STEPS] ? '0 : r_z[ppdb_pkg::CORDIC_STEPS];

endmodule

/* sv/ppdb_angle_fmt.sv */
// Pipelined conversion of a Q30 radian angle to rounded radians or degrees.
module ppdb_angle_fmt (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic                                   i_deg,
    input  logic signed [ppdb_pkg::SWEEP_W-1:0]    i_z,
    output logic signed [ppdb_pkg::ANGLE_WIDTH-1:0] o_angle
);

    logic                          r_sgn1, r_sgn2, r_sgn3, r_sgn4, r_sgn5;
    logic [ppdb_pkg::MAG_W-1:0]    r_mag1, r_mag2, r_mag3, r_mag4;
    logic [ppdb_pkg::PP_W-1:0]     r_hh, r_hl, r_lh, r_ll;
    logic [ppdb_pkg::DS_W-1:0]     w_dsum;
    logic [ppdb_pkg::R_W-1:0]      r_c0, r_c0b;
    logic [ppdb_pkg::DS_W-1:0]     r_p1, r_p2, w_drem;
    logic [ppdb_pkg::R_W-1:0]      w_deg, r_v, w_rnd;
    logic signed [ppdb_pkg::ANGLE_WIDTH-1:0] r_out;

    assign w_dsum = (ppdb_pkg::DS_W'(r_hh) << (ppdb_pkg::MLO_W + ppdb_pkg::RLO_W))
                  + (ppdb_pkg::DS_W'(r_hl) << ppdb_pkg::MLO_W)
                  + (ppdb_pkg::DS_W'(r_lh) << ppdb_pkg::RLO_W)
                  + ppdb_pkg::DS_W'(r_ll);
    assign w_drem = r_p1 - r_p2;
    assign w_deg  = r_c0b + ppdb_pkg::R_W'(w_drem >= ppdb_pkg::DS_W'(ppdb_pkg::DEG_DEN));
    assign w_rnd  = (r_v + ppdb_pkg::R_W'(64'd1 << (ppdb_pkg::ASH - 1))) >> ppdb_pkg::ASH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn1 <= i_z[ppdb_pkg::SWEEP_W-1];
            r_mag1 <= ppdb_pkg::MAG_W'(i_z[ppdb_pkg::SWEEP_W-1] ? -i_z : i_z);

            r_hh <= ppdb_pkg::PP_W'(r_mag1[ppdb_pkg::MAG_W-1 -: ppdb_pkg::MHI_W])
                  * ppdb_pkg::PP_W'(ppdb_pkg::DEG_RECIP[ppdb_pkg::R_W-1 -: ppdb_pkg::RHI_W]);
            r_hl <= ppdb_pkg::PP_W'(r_mag1[ppdb_pkg::MAG_W-1 -: ppdb_pkg::MHI_W])
                  * ppdb_pkg::PP_W'(ppdb_pkg::DEG_RECIP[ppdb_pkg::RLO_W-1:0]);
            r_lh <= ppdb_pkg::PP_W'(r_mag1[ppdb_pkg::MLO_W-1:0])
                  * ppdb_pkg::PP_W'(ppdb_pkg::DEG_RECIP[ppdb_pkg::R_W-1 -: ppdb_pkg::RHI_W]);
            r_ll <= ppdb_pkg::PP_W'(r_mag1[ppdb_pkg::MLO_W-1:0])
                  * ppdb_pkg::PP_W'(ppdb_pkg::DEG_RECIP[ppdb_pkg::RLO_W-1:0]);
            r_mag2 <= r_mag1;
            r_sgn2 <= r_sgn1;

            r_c0   <= w_dsum[ppdb_pkg::DS_W-1 -: ppdb_pkg::R_W];
            r_mag3 <= r_mag2;
            r_sgn3 <= r_sgn2;

            r_p1   <= ppdb_pkg::DS_W'(r_mag3) * ppdb_pkg::DS_W'(ppdb_pkg::DEG_NUM);
            r_p2   <= ppdb_pkg::DS_W'(r_c0) * ppdb_pkg::DS_W'(ppdb_pkg::DEG_DEN);
            r_c0b  <= r_c0;
            r_mag4 <= r_mag3;
            r_sgn4 <= r_sgn3;

            r_v    <= i_deg ? w_deg : ppdb_pkg::R_W'(r_mag4);
            r_sgn5 <= r_sgn4;

            r_out  <= ppdb_pkg::ANGLE_WIDTH'(r_sgn5 ? -w_rnd : w_rnd);
        end
    end

    assign o_angle = r_out;

endmodule

/* sv/point_pair_distance_bearing_unit.sv */
// Top level of the point pair distance and bearing unit.
//
// Input channel: i_in_valid with the four point coordinates (signed, 8 fraction
// bits); the unit drives o_in_stall. A request is taken at a clock edge with
// valid high and stall low.
// Output channel: o_out_valid with distance in meters and feet, the bearing from
// point 1 to point 2 and the sweep angle; the receiver drives i_out_stall.
// Unless the receiver stalls, a new request and a result can pass every cycle.
// The angle path, the 30-step CORDIC pipeline and then the six-stage angle
// scaling, is the longest; the distance results are delayed to match it.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and selects radians.
// i_cfg_wr_en with i_cfg_wr_data selects degrees (1) or radians (0); write it
// only while no request is in flight.
`include "assert_macros.svh"

module point_pair_distance_bearing_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_wr_en,
    input  logic                                     i_cfg_wr_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [ppdb_pkg::COORD_WIDTH-1:0]  i_first_x,
    input  logic signed [ppdb_pkg::COORD_WIDTH-1:0]  i_first_y,
    input  logic signed [ppdb_pkg::COORD_WIDTH-1:0]  i_second_x,
    input  logic signed [ppdb_pkg::COORD_WIDTH-1:0]  i_second_y,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [ppdb_pkg::DIST_M_WIDTH-1:0]        o_distance_meters,
    output logic [ppdb_pkg::DIST_FT_WIDTH-1:0]       o_dist_feet,
    output logic signed [ppdb_pkg::ANGLE_WIDTH-1:0]  o_bearing,
    output logic signed [ppdb_pkg::ANGLE_WIDTH-1:0]  o_sweep
);

    typedef struct packed {
        logic [ppdb_pkg::DIFF_W-1:0] root;
        logic [ppdb_pkg::DIFF_W+1:0] rem;
    } t_sq;

    function automatic t_sq sq_step(input logic [ppdb_pkg::DIFF_W+1:0] rem,
                                    input logic [ppdb_pkg::DIFF_W-1:0] root,
                                    input logic [1:0] pair);
        logic [ppdb_pkg::DIFF_W+3:0] cur;
        logic [ppdb_pkg::DIFF_W+3:0] trial;
        t_sq res;
        cur   = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (cur >= trial) begin
            res.rem  = (ppdb_pkg::DIFF_W+2)'(cur - trial);
            res.root = {root[ppdb_pkg::DIFF_W-2:0], 1'b1};
        end else begin
            res.rem  = (ppdb_pkg::DIFF_W+2)'(cur);
            res.root = {root[ppdb_pkg::DIFF_W-2:0], 1'b0};
        end
        return res;
    endfunction

    logic [ppdb_pkg::OUT_STAGE:0] r_vld;
    logic                         r_deg;
    logic                         w_en;

    logic signed [ppdb_pkg::DIFF_W-1:0] r_x1, r_y1, r_x2, r_y2, r_dx, r_dy;
    logic [ppdb_pkg::DIFF_W-1:0]        r_ax, r_ay;
    logic [ppdb_pkg::SQ_W-1:0]          r_sqa, r_sqb, r_sum;

    logic [ppdb_pkg::DIFF_W-1:0] r_root [ppdb_pkg::DIFF_W];
    logic [ppdb_pkg::DIFF_W+1:0] r_rem  [ppdb_pkg::DIFF_W];
    logic [ppdb_pkg::SQ_W-1:0]   r_rad  [ppdb_pkg::DIFF_W-1];
    t_sq                         n_sq   [ppdb_pkg::DIFF_W];

    logic [ppdb_pkg::DIFF_W-1:0] r_dist, r_dist1, r_dist2, r_dist3, r_dist4;
    logic [ppdb_pkg::FN_W-1:0]   r_fn, r_fn2, r_fn3, r_fn4;
    logic [ppdb_pkg::FP_W-1:0]   r_pph, r_ppl;
    logic [ppdb_pkg::FS_W-1:0]   w_fsum;
    logic [ppdb_pkg::FR_W-1:0]   r_q0, r_q0b;
    logic [ppdb_pkg::FN_W:0]     r_t, w_frem;
    logic [ppdb_pkg::DIST_FT_WIDTH-1:0] r_feet;
    logic [ppdb_pkg::DIST_M_WIDTH-1:0]  r_dist5;

    logic signed [ppdb_pkg::Z_W-1:0]         w_zb, w_z1, w_z2;
    logic signed [ppdb_pkg::SWEEP_W-1:0]     r_sw, r_bz;
    logic signed [ppdb_pkg::ANGLE_WIDTH-1:0] w_bear, w_swp;

    logic signed [ppdb_pkg::ANGLE_WIDTH-1:0] r_bear_d [ppdb_pkg::ANG_DLY];
    logic signed [ppdb_pkg::ANGLE_WIDTH-1:0] r_swp_d  [ppdb_pkg::ANG_DLY];
    logic [ppdb_pkg::DIST_FT_WIDTH-1:0]      r_feet_d [ppdb_pkg::DIST_DLY];
    logic [ppdb_pkg::DIST_M_WIDTH-1:0]       r_dm_d   [ppdb_pkg::DIST_DLY];

    assign w_en       = !r_vld[ppdb_pkg::OUT_STAGE] || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_deg <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[ppdb_pkg::OUT_STAGE-1:0], i_in_valid};
            end
            if (i_cfg_wr_en) begin
                r_deg <= i_cfg_wr_data;
            end
        end
    end

    always_comb begin
        n_sq[0] = sq_step('0, '0, r_sum[ppdb_pkg::SQ_W-1 -: 2]);
        for (int k = 1; k < ppdb_pkg::DIFF_W; k++) begin
            n_sq[k] = sq_step(r_rem[k-1], r_root[k-1],
                              r_rad[k-1][ppdb_pkg::SQ_W-1-2*k -: 2]);
        end
    end

    assign w_fsum = (ppdb_pkg::FS_W'(r_pph) << ppdb_pkg::FNLO_W) + ppdb_pkg::FS_W'(r_ppl);
    assign w_frem = {1'b0, r_fn4} - r_t;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1 <= ppdb_pkg::DIFF_W'(i_first_x);
            r_y1 <= ppdb_pkg::DIFF_W'(i_first_y);
            r_x2 <= ppdb_pkg::DIFF_W'(i_second_x);
            r_y2 <= ppdb_pkg::DIFF_W'(i_second_y);
            r_dx <= ppdb_pkg::DIFF_W'(i_second_x) - ppdb_pkg::DIFF_W'(i_first_x);
            r_dy <= ppdb_pkg::DIFF_W'(i_second_y) - ppdb_pkg::DIFF_W'(i_first_y);

            r_ax  <= r_dx[ppdb_pkg::DIFF_W-1] ? ppdb_pkg::DIFF_W'(-r_dx) : r_dx;
            r_ay  <= r_dy[ppdb_pkg::DIFF_W-1] ? ppdb_pkg::DIFF_W'(-r_dy) : r_dy;
            r_sqa <= ppdb_pkg::SQ_W'(r_ax) * ppdb_pkg::SQ_W'(r_ax);
            r_sqb <= ppdb_pkg::SQ_W'(r_ay) * ppdb_pkg::SQ_W'(r_ay);
            r_sum <= r_sqa + r_sqb;

            r_rad[0] <= r_sum;
            for (int k = 1; k < ppdb_pkg::DIFF_W - 1; k++) begin
                r_rad[k] <= r_rad[k-1];
            end
            for (int k = 0; k < ppdb_pkg::DIFF_W; k++) begin
                r_root[k] <= n_sq[k].root;
                r_rem[k]  <= n_sq[k].rem;
            end

            r_dist <= r_root[ppdb_pkg::DIFF_W-1]
                    + ppdb_pkg::DIFF_W'(r_rem[ppdb_pkg::DIFF_W-1]
                                        > {2'b00, r_root[ppdb_pkg::DIFF_W-1]});

            r_fn    <= ppdb_pkg::FN_W'(r_dist) * ppdb_pkg::FN_W'(ppdb_pkg::FEET_FRAC)
                     + ppdb_pkg::FN_W'(ppdb_pkg::BILLION / 2);
            r_dist1 <= r_dist;

            r_pph   <= ppdb_pkg::FP_W'(r_fn[ppdb_pkg::FN_W-1 -: ppdb_pkg::FNHI_W])
                     * ppdb_pkg::FP_W'(ppdb_pkg::FEET_RECIP);
            r_ppl   <= ppdb_pkg::FP_W'(r_fn[ppdb_pkg::FNLO_W-1:0])
                     * ppdb_pkg::FP_W'(ppdb_pkg::FEET_RECIP);
            r_fn2   <= r_fn;
            r_dist2 <= r_dist1;

            r_q0    <= w_fsum[ppdb_pkg::FS_W-1 -: ppdb_pkg::FR_W];
            r_fn3   <= r_fn2;
            r_dist3 <= r_dist2;

            r_t     <= (ppdb_pkg::FN_W+1)'(r_q0) * (ppdb_pkg::FN_W+1)'(ppdb_pkg::BILLION);
            r_q0b   <= r_q0;
            r_fn4   <= r_fn3;
            r_dist4 <= r_dist3;

            r_feet  <= ppdb_pkg::DIST_FT_WIDTH'(
                           (ppdb_pkg::DIFF_W+2)'(r_dist4)
                         + ((ppdb_pkg::DIFF_W+2)'(r_dist4) << 1)
                         + (ppdb_pkg::DIFF_W+2)'(r_q0b)
                         + (ppdb_pkg::DIFF_W+2)'(w_frem >= (ppdb_pkg::FN_W+1)'(ppdb_pkg::BILLION)));
            r_dist5 <= ppdb_pkg::DIST_M_WIDTH'(r_dist4);

            r_feet_d[0] <= r_feet;
            r_dm_d[0]   <= r_dist5;
            for (int k = 1; k < ppdb_pkg::DIST_DLY; k++) begin
                r_feet_d[k] <= r_feet_d[k-1];
                r_dm_d[k]   <= r_dm_d[k-1];
            end

            r_sw <= ppdb_pkg::SWEEP_W'(w_z2) - ppdb_pkg::SWEEP_W'(w_z1);
            r_bz <= ppdb_pkg::SWEEP_W'(w_zb);

            r_bear_d[0] <= w_bear;
            r_swp_d[0]  <= w_swp;
            for (int k = 1; k < ppdb_pkg::ANG_DLY; k++) begin
                r_bear_d[k] <= r_bear_d[k-1];
                r_swp_d[k]  <= r_swp_d[k-1];
            end
        end
    end

    ppdb_cordic u_cordic_bear (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_dx),
        .i_den (r_dy),
        .o_z   (w_zb)
    );

    ppdb_cordic u_cordic_first (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_x1),
        .i_den (r_y1),
        .o_z   (w_z1)
    );

    ppdb_cordic u_cordic_second (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_x2),
        .i_den (r_y2),
        .o_z   (w_z2)
    );

    ppdb_angle_fmt u_fmt_bear (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_deg   (r_deg),
        .i_z     (r_bz),
        .o_angle (w_bear)
    );

    ppdb_angle_fmt u_fmt_sweep (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_deg   (r_deg),
        .i_z     (r_sw),
        .o_angle (w_swp)
    );

    assign o_out_valid       = r_vld[ppdb_pkg::OUT_STAGE];
    assign o_distance_meters = r_dm_d[ppdb_pkg::DIST_DLY-1];
    assign o_dist_feet       = r_feet_d[ppdb_pkg::DIST_DLY-1];
    assign o_bearing         = r_bear_d[ppdb_pkg::ANG_DLY-1];
    assign o_sweep           = r_swp_d[ppdb_pkg::ANG_DLY-1];

    `PPDB_ASSERT_NEXT(a_request_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])
    `PPDB_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, o_in_stall, $stable(r_vld))
    `PPDB_ASSERT_NOW(a_feet_not_below_meters, i_clk, i_rst_n, o_out_valid, ppdb_pkg::DIST_FT_WIDTH'(o_distance_meters) <= o_dist_feet)
    `PPDB_ASSERT_NOW(a_zero_distance_bearing, i_clk, i_rst_n, o_out_valid && (o_distance_meters == '0), o_bearing == '0)

endmodule

/* test/tb_point_pair_distance_bearing_unit.sv */
// Testbench for the point pair distance and bearing unit with a bit-exact predictor.
`timescale 1ns / 100ps

module tb_point_pair_distance_bearing_unit;

    typedef struct packed {
        logic [ppdb_pkg::DIST_M_WIDTH-1:0]  dist_m;
        logic [ppdb_pkg::DIST_FT_WIDTH-1:0] dist_ft;
        logic [ppdb_pkg::ANGLE_WIDTH-1:0]   bearing;
        logic [ppdb_pkg::ANGLE_WIDTH-1:0]   sweep;
    } t_geo_result;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     LATENCY     = 39;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [ppdb_pkg::COORD_WIDTH-1:0] i_first_x = '0, i_first_y = '0;
    logic signed [ppdb_pkg::COORD_WIDTH-1:0] i_second_x = '0, i_second_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [ppdb_pkg::DIST_M_WIDTH-1:0] o_distance_meters;
    logic [ppdb_pkg::DIST_FT_WIDTH-1:0] o_dist_feet;
    logic signed [ppdb_pkg::ANGLE_WIDTH-1:0] o_bearing, o_sweep;

    point_pair_distance_bearing_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_geo_result expected_geo[$];
    bit  degrees_mode = 1'b0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;
    int  error_count = 0;
    longint cycle_count = 0;

    function automatic longint shr_arith(longint v, int s);
        return v < 0 ? ~((~v) >>> s) : (v >>> s);
    endfunction

    function automatic longint vector_angle(longint num, longint den);
        longint x, y, z, xs, ys, pi_q30;
        x = den * (64'sd1 <<< (60 - ppdb_pkg::COORD_WIDTH));
        y = num * (64'sd1 <<< (60 - ppdb_pkg::COORD_WIDTH));
        z = 0;
        pi_q30 = 4 * longint'(ppdb_pkg::ATAN_TAB[0]);
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? pi_q30 : -pi_q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ppdb_pkg::CORDIC_STEPS; i++) begin
            xs = shr_arith(x, i);
            ys = shr_arith(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(ppdb_pkg::ATAN_TAB[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ppdb_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic logic [ppdb_pkg::ANGLE_WIDTH-1:0] format_angle(longint z);
        logic [63:0] mag, q, rm, r;
        mag = z < 0 ? 64'(-z) : 64'(z);
        if (degrees_mode) begin
            q = mag / ppdb_pkg::DEG_DEN;
            rm = mag % ppdb_pkg::DEG_DEN;
            mag = q * ppdb_pkg::DEG_NUM + (rm * ppdb_pkg::DEG_NUM) / ppdb_pkg::DEG_DEN;
        end
        r = (mag + (64'd1 << (ppdb_pkg::ASH - 1))) >> ppdb_pkg::ASH;
        if (z < 0) r = -r;
        return r[ppdb_pkg::ANGLE_WIDTH-1:0];
    endfunction

    function automatic logic [63:0] rounded_root(logic [65:0] v);
        logic [67:0] root, rem, trial;
        root = 0;
        rem = 0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 68'(v[2*k +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        if (rem > root) root++;
        return root[63:0];
    endfunction

    function automatic t_geo_result predict_geometry(longint x1, longint y1,
                                                     longint x2, longint y2);
        t_geo_result g;
        longint dx, dy;
        logic [65:0] sq;
        logic [63:0] d, ft;
        dx = x2 - x1;
        dy = y2 - y1;
        sq = 66'(dx * dx) + 66'(dy * dy);
        d = rounded_root(sq);
        ft = 3 * d + (d * ppdb_pkg::FEET_FRAC + ppdb_pkg::BILLION / 2) / ppdb_pkg::BILLION;
        g.dist_m = d[ppdb_pkg::DIST_M_WIDTH-1:0];
        g.dist_ft = ft[ppdb_pkg::DIST_FT_WIDTH-1:0];
        g.bearing = format_angle(vector_angle(dx, dy));
        g.sweep = format_angle(vector_angle(x2, y2) - vector_angle(x1, y1));
        return g;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_points(logic [ppdb_pkg::COORD_WIDTH-1:0] x1,
                               logic [ppdb_pkg::COORD_WIDTH-1:0] y1,
                               logic [ppdb_pkg::COORD_WIDTH-1:0] x2,
                               logic [ppdb_pkg::COORD_WIDTH-1:0] y2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_x <= x1;
        i_first_y <= y1;
        i_second_x <= x2;
        i_second_y <= y2;
        expected_geo.push_back(predict_geometry($signed(x1), $signed(y1),
                                                $signed(x2), $signed(y2)));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_geo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_angle_unit(bit deg);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= deg;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        degrees_mode = deg;
    endtask

    function automatic logic [ppdb_pkg::COORD_WIDTH-1:0] rand_coord();
        unique case ($urandom_range(3))
            0: return ppdb_pkg::COORD_WIDTH'($urandom);
            1: return ppdb_pkg::COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
            2: return $urandom_range(1) ? {1'b0, {(ppdb_pkg::COORD_WIDTH-1){1'b1}}}
                                        : {1'b1, {(ppdb_pkg::COORD_WIDTH-1){1'b0}}};
            default: return ppdb_pkg::COORD_WIDTH'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    task automatic send_random(int count);
        logic [ppdb_pkg::COORD_WIDTH-1:0] a, b;
        for (int n = 0; n < count; n++) begin
            a = rand_coord();
            b = rand_coord();
            if ($urandom_range(9) == 0) send_points(a, b, a, b);
            else send_points(a, b, rand_coord(), rand_coord());
        end
    endtask

    task automatic test_directed();
        logic [ppdb_pkg::COORD_WIDTH-1:0] mx, mn, z, p1, m1, p256, m256;
        mx = {1'b0, {(ppdb_pkg::COORD_WIDTH-1){1'b1}}};
        mn = {1'b1, {(ppdb_pkg::COORD_WIDTH-1){1'b0}}};
        z = '0;
        p1 = ppdb_pkg::COORD_WIDTH'(1);
        m1 = ppdb_pkg::COORD_WIDTH'(-1);
        p256 = ppdb_pkg::COORD_WIDTH'(256);
        m256 = ppdb_pkg::COORD_WIDTH'(-256);
        for (int u = 0; u < 2; u++) begin
            set_angle_unit(u[0]);
            send_points(z, z, z, z);
            send_points(mn, mn, mx, mx);
            send_points(mx, mx, mn, mn);
            send_points(mx, mn, mn, mx);
            send_points(z, z, z, m256);
            send_points(z, p256, z, m256);
            send_points(ppdb_pkg::COORD_WIDTH'(5), ppdb_pkg::COORD_WIDTH'(7),
                        ppdb_pkg::COORD_WIDTH'(5), ppdb_pkg::COORD_WIDTH'(7));
            send_points(z, z, p256, z);
            send_points(z, z, m256, z);
            send_points(m1, m1, p1, p1);
            send_points(mn, z, z, mn);
        end
    endtask

    task automatic test_random_phases();
        int idle_pct[4] = '{0, 73, 0, 15};
        int stall_pct[4] = '{0, 0, 73, 15};
        for (int p = 0; p < 4; p++) begin
            set_angle_unit(p[0]);
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            send_random(350);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_back_pressure();
        set_angle_unit(1'b1);
        hold_cycles = 300;
        send_random(100);
        drain_results();
        send_random(50);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_geo_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_geo.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_geo.pop_front();
                if (o_distance_meters !== want.dist_m)
                    report_mismatch("distance_meters", o_distance_meters, want.dist_m);
                if (o_dist_feet !== want.dist_ft)
                    report_mismatch("dist_feet", o_dist_feet, want.dist_ft);
                if (o_bearing !== want.bearing)
                    report_mismatch("bearing", o_bearing, $signed(want.bearing));
                if (o_sweep !== want.sweep)
                    report_mismatch("sweep", o_sweep, $signed(want.sweep));
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_back_pressure();
        drain_results();
        if (error_count == 0 && expected_geo.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
